// ----- design/rhsv_pkg.sv -----
package rhsv_pkg;

	// Channel and result widths
	localparam int CHAN_W = 8;
	localparam int PIX_W  = 3 * CHAN_W;
	localparam int HUE_W  = 16;
	localparam int SAT_W  = 16;

	// Hue fraction bits (8..24); hue clamps to all ones above HUE_W
	localparam int FRAC_BITS = 16;

	// Hue divisor 6*d, d up to 255
	localparam int DIV_W = $clog2(6 * ((1 << CHAN_W) - 1) + 1);

	// One cell per quotient bit of the longer division
	localparam int NCELL = (FRAC_BITS > SAT_W) ? FRAC_BITS : SAT_W;

	localparam int OUT_W = ((HUE_W + SAT_W + CHAN_W + 7) / 8) * 8;

	// Word handed from cell to cell
	typedef struct packed {
		logic                 zero;   // max == min: hue and saturation are 0
		logic [CHAN_W-1:0]    hi;     // brightness, saturation divisor
		logic [DIV_W-1:0]     hdiv;   // 6*(max-min), hue divisor
		logic [CHAN_W-1:0]    srem;   // saturation partial remainder
		logic [SAT_W-1:0]     sbits;  // saturation dividend bits still to shift in
		logic [SAT_W-1:0]     squo;   // saturation quotient
		logic [DIV_W-1:0]     hrem;   // hue partial remainder
		logic [FRAC_BITS-1:0] hquo;   // hue quotient
	} rhsv_word_t;

	// Which divisions a cell steps
	typedef struct packed {
		logic sat_on;
		logic hue_on;
	} rhsv_step_t;

endpackage

// ----- design/rhsv_prep.sv -----
module rhsv_prep (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rhsv_pkg::PIX_W-1:0] pixel,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rhsv_pkg::rhsv_word_t      out_word
);
	import rhsv_pkg::*;

	logic [CHAN_W-1:0]        r, g, b, hi, lo, d;
	logic [DIV_W-1:0]         d6, num;
	logic [CHAN_W+SAT_W-1:0]  sdvd;
	rhsv_word_t               w;
	logic                     v_q;
	rhsv_word_t               word_q;

	always_comb begin
		r = pixel[3*CHAN_W-1:2*CHAN_W];
		g = pixel[2*CHAN_W-1:CHAN_W];
		b = pixel[CHAN_W-1:0];
		hi = (r > g) ? r : g;
		hi = (hi > b) ? hi : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		d  = hi - lo;
		d6 = (DIV_W'(d) << 2) + (DIV_W'(d) << 1);
		// sextant numerator, always in [0, 6d); modular arithmetic is exact here
		priority if (hi == r) begin
			num = (g >= b) ? (DIV_W'(g) - DIV_W'(b)) : (d6 + DIV_W'(g) - DIV_W'(b));
		end else if (hi == g) begin
			num = (DIV_W'(d) << 1) + DIV_W'(b) - DIV_W'(r);
		end else begin
			num = (DIV_W'(d) << 2) + DIV_W'(r) - DIV_W'(g);
		end
		// 65535*d; top byte is below max, so it seeds the remainder
		sdvd = {d, {SAT_W{1'b0}}} - (CHAN_W+SAT_W)'(d);

		w.zero  = (d == '0);
		w.hi    = hi;
		w.hdiv  = d6;
		w.srem  = sdvd[CHAN_W+SAT_W-1:SAT_W];
		w.sbits = sdvd[SAT_W-1:0];
		w.squo  = '0;
		w.hrem  = num;
		w.hquo  = '0;
	end

	assign in_ready  = ~v_q | out_ready;
	assign out_valid = v_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= w;
		end
	end

endmodule

// ----- design/rhsv_cell.sv -----
module rhsv_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rhsv_pkg::rhsv_step_t step,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  rhsv_pkg::rhsv_word_t up_word,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output rhsv_pkg::rhsv_word_t dn_word
);
	import rhsv_pkg::*;

	logic [CHAN_W:0] st;
	logic [DIV_W:0]  ht;
	logic            sge, hge;
	rhsv_word_t      nxt;
	logic            v_q;
	rhsv_word_t      word_q;

	// one restoring-division step for each quotient
	always_comb begin
		nxt = up_word;
		st  = {up_word.srem, up_word.sbits[SAT_W-1]};
		sge = (st >= {1'b0, up_word.hi});
		ht  = {up_word.hrem, 1'b0};
		hge = (ht >= {1'b0, up_word.hdiv});
		if (step.sat_on) begin
			nxt.srem  = sge ? CHAN_W'(st - {1'b0, up_word.hi}) : st[CHAN_W-1:0];
			nxt.sbits = {up_word.sbits[SAT_W-2:0], 1'b0};
			nxt.squo  = {up_word.squo[SAT_W-2:0], sge};
		end
		if (step.hue_on) begin
			nxt.hrem = hge ? DIV_W'(ht - {1'b0, up_word.hdiv}) : ht[DIV_W-1:0];
			nxt.hquo = {up_word.hquo[FRAC_BITS-2:0], hge};
		end
	end

	assign up_ready = ~v_q | dn_ready;
	assign dn_valid = v_q;
	assign dn_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= nxt;
		end
	end

	// remainders stay below their divisors
	a_srem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !word_q.zero |-> word_q.srem < word_q.hi)
		else $error("saturation remainder not below max");

	a_hrem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !word_q.zero |-> word_q.hrem < word_q.hdiv)
		else $error("hue remainder not below 6*d");

	// a stalled beat holds until taken
	a_dn_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && !dn_ready |=> dn_valid && $stable(dn_word))
		else $error("downstream beat changed while stalled");

endmodule

// ----- design/rgb_to_hsv_pixel_converter_top.sv -----
// Channel   Dir  tdata bits  Fields (low bit first)
// s_*       in   [23:0]      pixel (blue 7:0, green 15:8, red 23:16)
// m_*       out  [39:0]      hue [15:0], saturation [31:16], brightness [39:32]
//
// One pixel per clock sustained while m_tready stays high; the pipeline is
// one prep stage, then one cell per quotient bit.
// Each cell does one restoring-division step for saturation and hue at once.
// arst_n clears only the valid bits of the stages; payload is not reset.
// Every stage holds its own beat and loads whenever it is empty or its
// neighbor moves on, so a stall at m_tready fills bubbles before s_tready drops.
module rgb_to_hsv_pixel_converter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [rhsv_pkg::PIX_W-1:0] s_tdata,   // pixel
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [rhsv_pkg::OUT_W-1:0] m_tdata    // hue, saturation, brightness
);
	import rhsv_pkg::*;

	// chain links: index 0 is prep output, index NCELL is the output register
	logic       v   [NCELL+1];
	logic       rdy [NCELL+1];
	rhsv_word_t w   [NCELL+1];
	rhsv_step_t stp [NCELL];

	logic [HUE_W-1:0] hue_q;  // quotient clamped to hue width
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	rhsv_word_t       last;

	rhsv_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pixel     (s_tdata),
		.out_valid (v[0]),
		.out_ready (rdy[0]),
		.out_word  (w[0])
	);

	genvar i;
	generate
		for (i = 0; i < NCELL; i++) begin : g_cell
			// the shorter division runs in the last cells of the row
			assign stp[i] = '{sat_on: (i >= NCELL - SAT_W), hue_on: (i >= NCELL - FRAC_BITS)};

			rhsv_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.step     (stp[i]),
				.up_valid (v[i]),
				.up_ready (rdy[i]),
				.up_word  (w[i]),
				.dn_valid (v[i+1]),
				.dn_ready (rdy[i+1]),
				.dn_word  (w[i+1])
			);
		end
	endgenerate

	assign rdy[NCELL] = m_tready;
	assign last       = w[NCELL];

	// hue wider than 16 bits saturates at all ones
	generate
		if (FRAC_BITS > HUE_W) begin : g_hue_clamp
			assign hue_q = (|last.hquo[FRAC_BITS-1:HUE_W]) ? '1 : last.hquo[HUE_W-1:0];
		end else begin : g_hue_ext
			assign hue_q = HUE_W'(last.hquo);
		end
	endgenerate

	// grey or black pixel: hue and saturation are zero
	assign hue        = last.zero ? '0 : hue_q;
	assign saturation = last.zero ? '0 : last.squo;

	assign m_tvalid = v[NCELL];
	assign m_tdata  = OUT_W'({last.hi, saturation, hue});

	// input backs up only when a result is waiting at the output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// black pixel carries no color
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && last.hi == '0 |-> hue == '0 && saturation == '0)
		else $error("black pixel with nonzero hue or saturation");

	// saturation is full only when min is zero, i.e. d equals max
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && saturation == '1 |-> 2 * last.hdiv == 12 * DIV_W'(last.hi))
		else $error("full saturation without zero minimum");

endmodule
